// ===== rtl/core/tgc_pkg.sv =====
package tgc_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;

  localparam int RAW_W  = 12;
  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int DIST_W = 10;
  localparam int X_W    = 8;
  localparam int Y_W    = 9;
  localparam int Z_W    = 8;
  localparam int EV_W   = 3;

  localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SIZE_W   = $clog2(SIZE_MAX + 1);
  localparam int NUM_W    = RAW_W + SIZE_W;
  localparam int CNT_W    = $clog2(NUM_W + 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  typedef enum logic [CFG_AW-1:0] {
    CFG_X_LEFT    = 3'd0,
    CFG_X_RIGHT   = 3'd1,
    CFG_Y_TOP     = 3'd2,
    CFG_Y_BOTTOM  = 3'd3,
    CFG_MIN_PRESS = 3'd4,
    CFG_TIMEOUT   = 3'd5,
    CFG_LOCKOUT   = 3'd6,
    CFG_SWIPE_MIN = 3'd7
  } cfg_idx_e;

  localparam logic [RAW_W-1:0]  RST_X_LEFT    = 12'd150;
  localparam logic [RAW_W-1:0]  RST_X_RIGHT   = 12'd3800;
  localparam logic [RAW_W-1:0]  RST_Y_TOP     = 12'd130;
  localparam logic [RAW_W-1:0]  RST_Y_BOTTOM  = 12'd4000;
  localparam logic [MS_W-1:0]   RST_MIN_PRESS = 16'd100;
  localparam logic [MS_W-1:0]   RST_TIMEOUT   = 16'd100;
  localparam logic [MS_W-1:0]   RST_LOCKOUT   = 16'd100;
  localparam logic [DIST_W-1:0] RST_SWIPE_MIN = 10'd50;

  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 3'd0,
    EV_PRESS    = 3'd1,
    EV_TAP      = 3'd2,
    EV_SWIPE_LR = 3'd3,
    EV_SWIPE_RL = 3'd4,
    EV_SWIPE_TB = 3'd5,
    EV_SWIPE_BT = 3'd6
  } event_e;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic axis_y;
    logic save_x;
    logic save_y;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/touch_gesture_classifier_unit.sv =====
// touch gesture classifier
// input channel (in_valid_i/in_ready_o) takes one touch sample per beat: raw x, y,
// pressure, touched flag and a millisecond timestamp
// output channel (out_valid_o/out_ready_i) returns one result beat per input beat:
// event code, screen x/y for press or tap, and tap pressure
// config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i; the user must write
// only while no sample is in flight, the block itself does not enforce it
// each sample maps x then y through one shared radix-2 divider, 21 steps per axis;
// once the y result is saved the block updates the output in its decide state, and a new
// beat is taken only after the previous sample has been committed
// the result sits in an output register; a stalled receiver holds it there and the
// next sample is still accepted and mapped, waiting only at the final update until
// the output register frees up
// reset clears the gesture times and points, restores the calibration and timing
// registers to their defaults and drops out_valid_o
module touch_gesture_classifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tgc_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [tgc_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tgc_pkg::RAW_W-1:0]   raw_x_i,
  input  logic [tgc_pkg::RAW_W-1:0]   raw_y_i,
  input  logic [tgc_pkg::RAW_W-1:0]   raw_pressure_i,
  input  logic                        is_touched_i,
  input  logic [tgc_pkg::TIME_W-1:0]  now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tgc_pkg::EV_W-1:0]    event_res_o,
  output logic [tgc_pkg::X_W-1:0]     screen_x_o,
  output logic [tgc_pkg::Y_W-1:0]     screen_y_o,
  output logic [tgc_pkg::Z_W-1:0]     tap_pressure_o
);

  tgc_pkg::cmd_t cmd;
  tgc_pkg::sts_t sts;

  tgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tgc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .raw_x_i        (raw_x_i),
    .raw_y_i        (raw_y_i),
    .raw_pressure_i (raw_pressure_i),
    .is_touched_i   (is_touched_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .tap_pressure_o (tap_pressure_o)
  );

endmodule

// ===== rtl/core/tgc_div.sv =====
module tgc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tgc_pkg::NUM_W-1:0]  dividend_i,
  input  logic [tgc_pkg::RAW_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [tgc_pkg::NUM_W-1:0]  quotient_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [tgc_pkg::CNT_W-1:0]  cnt_q;
  logic [tgc_pkg::NUM_W-1:0]  quo_q;
  logic [tgc_pkg::RAW_W-1:0]  rem_q;
  logic [tgc_pkg::RAW_W-1:0]  dvs_q;
  logic [tgc_pkg::RAW_W:0]    rem_sh;
  logic [tgc_pkg::RAW_W:0]    diff;
  logic                       ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[tgc_pkg::NUM_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= tgc_pkg::CNT_W'(tgc_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tgc_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[tgc_pkg::NUM_W-2:0], ge};
      rem_q <= ge ? diff[tgc_pkg::RAW_W-1:0] : rem_sh[tgc_pkg::RAW_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/tgc_dp.sv =====
module tgc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tgc_pkg::cmd_t               cmd_i,
  output tgc_pkg::sts_t               sts_o,
  input  logic                        cfg_we_i,
  input  logic [tgc_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [tgc_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic [tgc_pkg::RAW_W-1:0]   raw_x_i,
  input  logic [tgc_pkg::RAW_W-1:0]   raw_y_i,
  input  logic [tgc_pkg::RAW_W-1:0]   raw_pressure_i,
  input  logic                        is_touched_i,
  input  logic [tgc_pkg::TIME_W-1:0]  now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tgc_pkg::EV_W-1:0]    event_res_o,
  output logic [tgc_pkg::X_W-1:0]     screen_x_o,
  output logic [tgc_pkg::Y_W-1:0]     screen_y_o,
  output logic [tgc_pkg::Z_W-1:0]     tap_pressure_o
);

  // configuration
  logic [tgc_pkg::RAW_W-1:0]  x_left_q, x_right_q, y_top_q, y_bottom_q;
  logic [tgc_pkg::MS_W-1:0]   min_press_q, timeout_q, lockout_q;
  logic [tgc_pkg::DIST_W-1:0] swipe_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_left_q    <= tgc_pkg::RST_X_LEFT;
      x_right_q   <= tgc_pkg::RST_X_RIGHT;
      y_top_q     <= tgc_pkg::RST_Y_TOP;
      y_bottom_q  <= tgc_pkg::RST_Y_BOTTOM;
      min_press_q <= tgc_pkg::RST_MIN_PRESS;
      timeout_q   <= tgc_pkg::RST_TIMEOUT;
      lockout_q   <= tgc_pkg::RST_LOCKOUT;
      swipe_min_q <= tgc_pkg::RST_SWIPE_MIN;
    end else if (cfg_we_i) begin
      case (tgc_pkg::cfg_idx_e'(cfg_addr_i))
        tgc_pkg::CFG_X_LEFT:    x_left_q    <= cfg_wdata_i[tgc_pkg::RAW_W-1:0];
        tgc_pkg::CFG_X_RIGHT:   x_right_q   <= cfg_wdata_i[tgc_pkg::RAW_W-1:0];
        tgc_pkg::CFG_Y_TOP:     y_top_q     <= cfg_wdata_i[tgc_pkg::RAW_W-1:0];
        tgc_pkg::CFG_Y_BOTTOM:  y_bottom_q  <= cfg_wdata_i[tgc_pkg::RAW_W-1:0];
        tgc_pkg::CFG_MIN_PRESS: min_press_q <= cfg_wdata_i[tgc_pkg::MS_W-1:0];
        tgc_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i[tgc_pkg::MS_W-1:0];
        tgc_pkg::CFG_LOCKOUT:   lockout_q   <= cfg_wdata_i[tgc_pkg::MS_W-1:0];
        tgc_pkg::CFG_SWIPE_MIN: swipe_min_q <= cfg_wdata_i[tgc_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat capture
  logic [tgc_pkg::RAW_W-1:0]  raw_x_q, raw_y_q, pz_q;
  logic                       touched_q;
  logic [tgc_pkg::TIME_W-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_x_q   <= raw_x_i;
      raw_y_q   <= raw_y_i;
      pz_q      <= raw_pressure_i;
      touched_q <= is_touched_i;
      now_q     <= now_ms_i;
    end
  end

  // calibration mapping operands
  logic [tgc_pkg::RAW_W-1:0]  raw_sel, lo_sel, hi_sel;
  logic [tgc_pkg::SIZE_W-1:0] size_sel;
  logic [tgc_pkg::RAW_W:0]    num, den;
  logic [tgc_pkg::RAW_W-1:0]  num_mag, den_mag;
  logic [tgc_pkg::NUM_W-1:0]  product;
  logic                       force_zero;

  always_comb begin
    raw_sel  = cmd_i.axis_y ? raw_y_q : raw_x_q;
    lo_sel   = cmd_i.axis_y ? y_top_q : x_left_q;
    hi_sel   = cmd_i.axis_y ? y_bottom_q : x_right_q;
    size_sel = cmd_i.axis_y ? tgc_pkg::SIZE_W'(tgc_pkg::SCREEN_HEIGHT)
                            : tgc_pkg::SIZE_W'(tgc_pkg::SCREEN_WIDTH);
    num      = {1'b0, raw_sel} - {1'b0, lo_sel};
    den      = {1'b0, hi_sel} - {1'b0, lo_sel};
    num_mag  = num[tgc_pkg::RAW_W] ? tgc_pkg::RAW_W'(-num) : num[tgc_pkg::RAW_W-1:0];
    den_mag  = den[tgc_pkg::RAW_W] ? tgc_pkg::RAW_W'(-den) : den[tgc_pkg::RAW_W-1:0];
    product  = tgc_pkg::NUM_W'(num_mag) * tgc_pkg::NUM_W'(size_sel);
    // zero divisor or negative quotient both end at coordinate zero
    force_zero = (den == '0) || (num[tgc_pkg::RAW_W] ^ den[tgc_pkg::RAW_W]);
  end

  logic                       div_done;
  logic [tgc_pkg::NUM_W-1:0]  quo;
  logic                       force_zero_q;

  tgc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (product),
    .divisor_i  (den_mag),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  logic [tgc_pkg::X_W-1:0] map_x_q;
  logic [tgc_pkg::Y_W-1:0] map_y_q;
  logic [tgc_pkg::X_W-1:0] clamp_x;
  logic [tgc_pkg::Y_W-1:0] clamp_y;

  always_comb begin
    clamp_x = (quo > tgc_pkg::NUM_W'(tgc_pkg::SCREEN_WIDTH - 1))
            ? tgc_pkg::X_W'(tgc_pkg::SCREEN_WIDTH - 1) : quo[tgc_pkg::X_W-1:0];
    clamp_y = (quo > tgc_pkg::NUM_W'(tgc_pkg::SCREEN_HEIGHT - 1))
            ? tgc_pkg::Y_W'(tgc_pkg::SCREEN_HEIGHT - 1) : quo[tgc_pkg::Y_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) force_zero_q <= force_zero;
    if (cmd_i.save_x)    map_x_q <= force_zero_q ? '0 : clamp_x;
    if (cmd_i.save_y)    map_y_q <= force_zero_q ? '0 : clamp_y;
  end

  // gesture state
  logic [tgc_pkg::TIME_W-1:0] start_t_q, end_t_q, lock_q;
  logic [tgc_pkg::TIME_W-1:0] start_t_d, end_t_d, lock_d;
  tgc_pkg::point_t            sp_q, ep_q, sp_d, ep_d, t_pt;

  logic [tgc_pkg::TIME_W-1:0] min32, tmo32, lock32;
  logic [tgc_pkg::TIME_W-1:0] start_plus_min, end_plus_tmo, held;
  logic                       pz_ok, press_go, late, rel_go, abandon, wait_rel;
  logic [tgc_pkg::X_W:0]      dx;
  logic [tgc_pkg::Y_W:0]      dy;
  logic [tgc_pkg::X_W-1:0]    ax;
  logic [tgc_pkg::Y_W-1:0]    ay;
  logic [tgc_pkg::DIST_W-1:0] ax_w, ay_w;
  logic                       swipe, dx_pos, dy_pos;

  tgc_pkg::event_e           ev_d, ev_q;
  logic [tgc_pkg::X_W-1:0]   sx_d, sx_q;
  logic [tgc_pkg::Y_W-1:0]   sy_d, sy_q;
  logic [tgc_pkg::Z_W-1:0]   tp_d, tp_q;
  logic                      out_valid_q;

  always_comb begin
    min32  = {{(tgc_pkg::TIME_W-tgc_pkg::MS_W){1'b0}}, min_press_q};
    tmo32  = {{(tgc_pkg::TIME_W-tgc_pkg::MS_W){1'b0}}, timeout_q};
    lock32 = {{(tgc_pkg::TIME_W-tgc_pkg::MS_W){1'b0}}, lockout_q};
    start_plus_min = start_t_q + min32;
    end_plus_tmo   = end_t_q + tmo32;
    held           = end_t_q - start_t_q;

    pz_ok    = (pz_q[tgc_pkg::RAW_W-1:tgc_pkg::Z_W] == '0) && (pz_q[tgc_pkg::Z_W-1:0] != '0);
    press_go = touched_q && (now_q > lock_q);
    late     = now_q > start_plus_min;
    rel_go   = (end_t_q != '0) && (held > min32) && (end_plus_tmo > now_q);
    abandon  = (end_t_q != '0) && (start_plus_min > end_t_q) && (now_q > end_plus_tmo);
    wait_rel = now_q < end_plus_tmo;

    dx     = {1'b0, sp_q.x} - {1'b0, ep_q.x};
    dy     = {1'b0, sp_q.y} - {1'b0, ep_q.y};
    ax     = dx[tgc_pkg::X_W] ? tgc_pkg::X_W'(-dx) : dx[tgc_pkg::X_W-1:0];
    ay     = dy[tgc_pkg::Y_W] ? tgc_pkg::Y_W'(-dy) : dy[tgc_pkg::Y_W-1:0];
    ax_w   = tgc_pkg::DIST_W'(ax);
    ay_w   = tgc_pkg::DIST_W'(ay);
    dx_pos = !dx[tgc_pkg::X_W] && (dx != '0);
    dy_pos = !dy[tgc_pkg::Y_W] && (dy != '0);
    swipe  = ((ax_w > swipe_min_q) && (ay_w < (ax_w >> 1)))
          || ((ay_w > swipe_min_q) && (ax_w < (ay_w >> 1)));

    t_pt.x = map_x_q;
    t_pt.y = map_y_q;
    t_pt.z = pz_q[tgc_pkg::Z_W-1:0];

    start_t_d = start_t_q;
    end_t_d   = end_t_q;
    lock_d    = lock_q;
    sp_d      = sp_q;
    ep_d      = ep_q;
    ev_d      = tgc_pkg::EV_NONE;
    sx_d      = '0;
    sy_d      = '0;
    tp_d      = '0;

    if (pz_ok) begin
      if (press_go) begin
        if (late) begin
          if (sp_q == '0) sp_d = t_pt;
          ep_d = t_pt;
        end
        end_t_d = now_q;
        ev_d    = tgc_pkg::EV_PRESS;
        sx_d    = map_x_q;
        sy_d    = map_y_q;
      end else if (rel_go) begin
        lock_d    = now_q + lock32;
        start_t_d = now_q;
        sp_d      = '0;
        end_t_d   = '0;
        if (swipe) begin
          if (ax_w > ay_w) begin
            ev_d = dx_pos ? tgc_pkg::EV_SWIPE_LR : tgc_pkg::EV_SWIPE_RL;
          end else begin
            ev_d = dy_pos ? tgc_pkg::EV_SWIPE_TB : tgc_pkg::EV_SWIPE_BT;
          end
        end else begin
          ev_d = tgc_pkg::EV_TAP;
          sx_d = ep_q.x;
          sy_d = ep_q.y;
          tp_d = ep_q.z;
        end
      end else if (abandon || !wait_rel) begin
        start_t_d = now_q;
        sp_d      = '0;
        end_t_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_t_q   <= '0;
      end_t_q     <= '0;
      lock_q      <= '0;
      sp_q        <= '0;
      ep_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        start_t_q <= start_t_d;
        end_t_q   <= end_t_d;
        lock_q    <= lock_d;
        sp_q      <= sp_d;
        ep_q      <= ep_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ev_q <= ev_d;
      sx_q <= sx_d;
      sy_q <= sy_d;
      tp_q <= tp_d;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign screen_x_o     = sx_q;
  assign screen_y_o     = sy_q;
  assign tap_pressure_o = tp_q;

endmodule

// ===== rtl/core/tgc_ctrl.sv =====
module tgc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tgc_pkg::sts_t  sts_i,
  output tgc_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_START_X = 5'b00010,
    ST_WAIT_X  = 5'b00100,
    ST_WAIT_Y  = 5'b01000,
    ST_DECIDE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START_X;
        end
      end
      ST_START_X: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (sts_i.div_done) begin
          cmd_o.save_x    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.axis_y    = 1'b1;
          state_d         = ST_WAIT_Y;
        end
      end
      ST_WAIT_Y: begin
        if (sts_i.div_done) begin
          cmd_o.save_y = 1'b1;
          state_d      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_starts_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_START_X))
    else $error("accepted beat did not start x mapping");

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_WAIT_X || state_q == ST_WAIT_Y))
    else $error("divider finished outside a wait state");

  a_x_then_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT_X && sts_i.div_done) |=> (state_q == ST_WAIT_Y))
    else $error("y mapping did not follow x");

  a_div_multicycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !sts_i.div_done)
    else $error("divider finished one cycle after start");

endmodule
